FILE: sv/tcw_pkg.sv
// Package for the text console character writer: payload types, microcode and helpers.
package tcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 8;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [7:0] CODE_BACKSPACE      = 8'h08;
  localparam logic [7:0] CODE_TAB            = 8'h09;
  localparam logic [7:0] CODE_NEWLINE        = 8'h0A;
  localparam logic [7:0] CODE_RETURN         = 8'h0D;
  localparam logic [7:0] CODE_SPACE          = 8'h20;
  localparam logic [7:0] CODE_LAST_PRINTABLE = 8'h7F;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } result_t;

  typedef logic [3:0] upc_t;

  localparam upc_t STEP_IDLE      = 4'd0;
  localparam upc_t STEP_PUT       = 4'd1;
  localparam upc_t STEP_CHECK     = 4'd2;
  localparam upc_t STEP_PRIME     = 4'd3;
  localparam upc_t STEP_COPY      = 4'd4;
  localparam upc_t STEP_COPY_LAST = 4'd5;
  localparam upc_t STEP_BLANK     = 4'd6;
  localparam upc_t STEP_FINISH    = 4'd7;
  localparam upc_t STEP_CLEAR     = 4'd8;
  localparam upc_t STEP_CLR_FILL  = 4'd9;
  localparam upc_t STEP_READ      = 4'd10;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_HOME,
    CUR_LAST_ROW
  } cur_op_e;

  typedef enum logic [1:0] {
    PINIT_NONE,
    PINIT_SCROLL,
    PINIT_ZERO
  } pinit_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_INDEX
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CHAR,
    WR_COPY,
    WR_BLANK
  } wr_src_e;

  typedef enum logic [1:0] {
    BR_SEQ,
    BR_JUMP,
    BR_TAKEN_IF,
    BR_STAY_IF
  } br_e;

  typedef enum logic [1:0] {
    C_ROW_OK,
    C_RD_MORE,
    C_WR_MORE
  } cond_e;

  typedef struct packed {
    cur_op_e cur_op;
    pinit_e  pinit;
    logic    rd_inc;
    logic    wr_inc;
    rd_sel_e rd_sel;
    wr_src_e wr_src;
    br_e     br;
    cond_e   cond;
    upc_t    target;
    logic    done;
  } ctrl_t;

  typedef struct packed {
    logic row_ok;
    logic rd_more;
    logic wr_more;
  } cond_t;

  localparam ctrl_t CTRL_NOP = '{
    cur_op: CUR_HOLD, pinit: PINIT_NONE, rd_inc: 1'b0, wr_inc: 1'b0,
    rd_sel: RD_NONE, wr_src: WR_NONE, br: BR_SEQ, cond: C_ROW_OK,
    target: STEP_IDLE, done: 1'b0
  };

  function automatic ctrl_t ucode(input upc_t step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      STEP_PUT: begin
        c.cur_op = CUR_PUT;
        c.wr_src = WR_CHAR;
      end
      STEP_CHECK: begin
        c.pinit  = PINIT_SCROLL;
        c.br     = BR_TAKEN_IF;
        c.cond   = C_ROW_OK;
        c.target = STEP_FINISH;
      end
      STEP_PRIME: begin
        c.rd_sel = RD_PTR;
        c.rd_inc = 1'b1;
      end
      STEP_COPY: begin
        c.rd_sel = RD_PTR;
        c.rd_inc = 1'b1;
        c.wr_src = WR_COPY;
        c.wr_inc = 1'b1;
        c.br     = BR_STAY_IF;
        c.cond   = C_RD_MORE;
        c.target = STEP_COPY_LAST;
      end
      STEP_COPY_LAST: begin
        c.wr_src = WR_COPY;
        c.wr_inc = 1'b1;
      end
      STEP_BLANK: begin
        c.cur_op = CUR_LAST_ROW;
        c.wr_src = WR_BLANK;
        c.wr_inc = 1'b1;
        c.br     = BR_STAY_IF;
        c.cond   = C_WR_MORE;
        c.target = STEP_FINISH;
      end
      STEP_FINISH: begin
        c.done   = 1'b1;
        c.br     = BR_JUMP;
        c.target = STEP_IDLE;
      end
      STEP_CLEAR: begin
        c.cur_op = CUR_HOME;
        c.pinit  = PINIT_ZERO;
      end
      STEP_CLR_FILL: begin
        c.wr_src = WR_BLANK;
        c.wr_inc = 1'b1;
        c.br     = BR_STAY_IF;
        c.cond   = C_WR_MORE;
        c.target = STEP_FINISH;
      end
      STEP_READ: begin
        c.rd_sel = RD_INDEX;
        c.br     = BR_JUMP;
        c.target = STEP_FINISH;
      end
      default: begin
        c = CTRL_NOP;
      end
    endcase
    return c;
  endfunction

  function automatic logic is_printable(input logic [7:0] code);
    return (code >= CODE_SPACE) && (code <= CODE_LAST_PRINTABLE);
  endfunction

endpackage

FILE: sv/tcw_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module tcw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [1:0]      op_i,
  input  tcw_pkg::cond_t  cond_i,
  output tcw_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);

  tcw_pkg::upc_t upc_q, upc_d;
  tcw_pkg::ctrl_t ctrl;
  logic cond_hit;

  assign ctrl   = tcw_pkg::ucode(upc_q);
  assign ctrl_o = ctrl;
  assign busy_o = (upc_q != tcw_pkg::STEP_IDLE);

  always_comb begin
    case (ctrl.cond)
      tcw_pkg::C_ROW_OK:  cond_hit = cond_i.row_ok;
      tcw_pkg::C_RD_MORE: cond_hit = cond_i.rd_more;
      tcw_pkg::C_WR_MORE: cond_hit = cond_i.wr_more;
      default:            cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (upc_q == tcw_pkg::STEP_IDLE) begin
      if (accept_i) begin
        case (op_i)
          tcw_pkg::OP_PUT:   upc_d = tcw_pkg::STEP_PUT;
          tcw_pkg::OP_READ:  upc_d = tcw_pkg::STEP_READ;
          tcw_pkg::OP_CLEAR: upc_d = tcw_pkg::STEP_CLEAR;
          default:           upc_d = tcw_pkg::STEP_FINISH;
        endcase
      end
    end else begin
      case (ctrl.br)
        tcw_pkg::BR_SEQ:      upc_d = upc_q + tcw_pkg::upc_t'(1);
        tcw_pkg::BR_JUMP:     upc_d = ctrl.target;
        tcw_pkg::BR_TAKEN_IF: upc_d = cond_hit ? ctrl.target : upc_q + tcw_pkg::upc_t'(1);
        tcw_pkg::BR_STAY_IF:  upc_d = cond_hit ? upc_q : ctrl.target;
        default:              upc_d = tcw_pkg::STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= tcw_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

FILE: sv/tcw_cursor.sv
// Cursor registers and the put-character cursor arithmetic.
module tcw_cursor #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF,
  localparam int CELLS   = ROWS * COLUMNS,
  localparam int PW      = $clog2(CELLS + COLUMNS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcw_pkg::cur_op_e cur_op_i,
  input  logic [7:0]       char_code_i,
  output logic [PW-1:0]    lin_pos_o,
  output logic             row_ok_o
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS + 1);
  localparam int TW = $clog2(TAB_STEP);
  localparam int SW = $clog2(COLUMNS + TAB_STEP);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [TW-1:0] ph_q, ph_d;
  logic [SW-1:0] col_n;
  logic [TW-1:0] ph_inc, ph_dec;

  assign ph_inc = (ph_q == TW'(TAB_STEP - 1)) ? '0 : ph_q + TW'(1);
  assign ph_dec = (ph_q == '0) ? TW'(TAB_STEP - 1) : ph_q - TW'(1);

  always_comb begin
    col_n = SW'(col_q);
    row_d = row_q;
    ph_d  = ph_q;
    case (cur_op_i)
      tcw_pkg::CUR_PUT: begin
        case (char_code_i)
          tcw_pkg::CODE_BACKSPACE: begin
            if (col_q != '0) begin
              col_n = col_n - SW'(1);
              ph_d  = ph_dec;
            end
          end
          tcw_pkg::CODE_TAB: begin
            col_n = col_n + SW'(TAB_STEP) - SW'(ph_q);
            ph_d  = '0;
          end
          tcw_pkg::CODE_RETURN: begin
            col_n = '0;
            ph_d  = '0;
          end
          tcw_pkg::CODE_NEWLINE: begin
            col_n = '0;
            ph_d  = '0;
            row_d = row_q + RW'(1);
          end
          default: begin
            if (tcw_pkg::is_printable(char_code_i)) begin
              col_n = col_n + SW'(1);
              ph_d  = ph_inc;
            end
          end
        endcase
        if (col_n >= SW'(COLUMNS)) begin
          col_n = '0;
          ph_d  = '0;
          row_d = row_d + RW'(1);
        end
      end
      tcw_pkg::CUR_HOME: begin
        col_n = '0;
        row_d = '0;
        ph_d  = '0;
      end
      tcw_pkg::CUR_LAST_ROW: begin
        row_d = RW'(ROWS - 1);
      end
      default: begin
        col_n = SW'(col_q);
      end
    endcase
    col_d = col_n[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ph_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ph_q  <= ph_d;
    end
  end

  assign lin_pos_o = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
  assign row_ok_o  = (row_q < RW'(ROWS));

endmodule

FILE: sv/tcw_screen.sv
// Screen cell memory with the read and write pointers used by scroll and clear.
module tcw_screen #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcw_pkg::ctrl_t ctrl_i,
  input  logic [7:0]     attr_i,
  input  logic [7:0]     char_code_i,
  input  logic [10:0]    cell_index_i,
  input  logic [AW-1:0]  cur_addr_i,
  output logic [15:0]    rdata_o,
  output logic           rd_more_o,
  output logic           wr_more_o
);

  logic [15:0]    mem [CELLS];
  logic [15:0]    rdata_q;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW+10:0] idx_ext;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           rd_en, wr_en;
  logic [15:0]    wdata;

  assign idx_ext = {{AW{1'b0}}, cell_index_i};

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = rd_ptr_q;
    case (ctrl_i.rd_sel)
      tcw_pkg::RD_PTR:   rd_addr = rd_ptr_q;
      tcw_pkg::RD_INDEX: rd_addr = idx_ext[AW-1:0];
      default:           rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = wr_ptr_q;
    wdata   = {attr_i, tcw_pkg::CODE_SPACE};
    case (ctrl_i.wr_src)
      tcw_pkg::WR_CHAR: begin
        wr_en   = tcw_pkg::is_printable(char_code_i);
        wr_addr = cur_addr_i;
        wdata   = {attr_i, char_code_i};
      end
      tcw_pkg::WR_COPY:  wdata = rdata_q;
      tcw_pkg::WR_BLANK: wdata = {attr_i, tcw_pkg::CODE_SPACE};
      default:           wr_en = 1'b0;
    endcase
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    case (ctrl_i.pinit)
      tcw_pkg::PINIT_SCROLL: begin
        rd_ptr_d = AW'(COLUMNS);
        wr_ptr_d = '0;
      end
      tcw_pkg::PINIT_ZERO: begin
        wr_ptr_d = '0;
      end
      default: begin
        if (ctrl_i.rd_inc) begin
          rd_ptr_d = rd_ptr_q + AW'(1);
        end
        if (ctrl_i.wr_inc) begin
          wr_ptr_d = wr_ptr_q + AW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rdata_o   = rdata_q;
  assign rd_more_o = (rd_ptr_q != AW'(CELLS - 1));
  assign wr_more_o = (wr_ptr_q != AW'(CELLS - 1));

endmodule

FILE: sv/text_console_char_writer_unit.sv
// Top level of the text console character writer.
// Each command runs a chain of microcode steps ending in FINISH: a read runs READ, a put PUT and
// CHECK, then PRIME, COPY, COPY_LAST and BLANK if it scrolls; a clear CLEAR and CLR_FILL.
// One item at a time; the next may start in the cycle its predecessor's result is strobed.
// Scroll and clear time is set by the single write port of the cell memory (one cell a cycle).
// Reset clears cursor, attribute (0x0F) and control; cells are undefined until cleared or written.
// The result is strobed for one cycle and cannot be stalled.
module text_console_char_writer_unit #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::cmd_t    cmd_i,
  input  logic             attr_we_i,
  input  logic [7:0]       attr_wdata_i,
  output logic             result_valid_o,
  output tcw_pkg::result_t result_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + COLUMNS);

  logic              accept;
  tcw_pkg::cmd_t     cmd_q;
  logic [7:0]        attr_q;
  tcw_pkg::ctrl_t    ctrl;
  tcw_pkg::cond_t    cond;
  logic [PW-1:0]     lin_pos;
  logic [PW+10:0]    lin_ext;
  logic [15:0]       rdata;
  logic              idx_ok;
  tcw_pkg::result_t  result_q, result_d;
  logic              result_valid_q;

  assign accept = start && !busy;

  tcw_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (cmd_i.op),
    .cond_i   (cond),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  tcw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cur_op_i    (ctrl.cur_op),
    .char_code_i (cmd_q.char_code),
    .lin_pos_o   (lin_pos),
    .row_ok_o    (cond.row_ok)
  );

  tcw_screen #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_screen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .attr_i       (attr_q),
    .char_code_i  (cmd_q.char_code),
    .cell_index_i (cmd_q.cell_index),
    .cur_addr_i   (lin_pos[AW-1:0]),
    .rdata_o      (rdata),
    .rd_more_o    (cond.rd_more),
    .wr_more_o    (cond.wr_more)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign lin_ext = {11'b0, lin_pos};
  assign idx_ok  = ({21'b0, cmd_q.cell_index} < 32'(CELLS));

  always_comb begin
    result_d.cursor_position = lin_ext[10:0];
    result_d.cell_data       = (cmd_q.op == tcw_pkg::OP_READ && idx_ok) ? rdata : 16'h0000;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= ctrl.done;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted beat did not start the sequencer");

  a_idle_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> cond.row_ok) else $error("cursor row out of range while idle");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (cmd_q.op != tcw_pkg::OP_READ)) |-> (result_o.cell_data == 16'h0000))
    else $error("cell data nonzero for a non-read beat");
`endif

endmodule
